### hdl/sort_merge_index_xor_sum_assert.svh
// assertion macros for the sort, merge and index-xor-sum block
`ifndef SORT_MERGE_INDEX_XOR_SUM_ASSERT_SVH
`define SORT_MERGE_INDEX_XOR_SUM_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SMX_ASSERT_IMPLIES(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define SMX_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`else

`define SMX_ASSERT_IMPLIES(label, clk, rst, pre, post, msg)
`define SMX_ASSERT_NEXT(label, clk, rst, pre, post, msg)

`endif

`endif

### hdl/smx_pkg.sv
package smx_pkg;

  localparam int MAX_LEN = 1024;
  localparam int ADDR_W  = $clog2(MAX_LEN);
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int MRG_W   = $clog2(2 * MAX_LEN + 1);
  localparam int DATA_W  = 32;

  // result codes
  localparam logic [1:0] SUM_A = 2'd0;
  localparam logic [1:0] SUM_B = 2'd1;
  localparam logic [1:0] SUM_M = 2'd2;

  typedef struct packed {
    logic       load;
    logic       sel_b;
    logic       init_sort;
    logic       rd_i;
    logic       ld_key;
    logic       rd_jm1;
    logic       wr_key;
    logic       wr_shift;
    logic       init_sum;
    logic       rd_k;
    logic       acc_k;
    logic       init_merge;
    logic       rd_merge;
    logic       acc_merge;
    logic       emit;
    logic [1:0] code;
    logic       last;
    logic       clr_counts;
  } cmd_t;

  typedef struct packed {
    logic i_done;
    logic j_zero;
    logic key_lt;
    logic k_done;
    logic merge_done;
    logic out_free;
  } status_t;

endpackage

### hdl/smx_ctrl.sv
module smx_ctrl
  import smx_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  logic    last_item,
  output logic    item_ready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [3:0] ST_LOAD      = 4'd0;
  localparam logic [3:0] ST_SORT_KEY  = 4'd1;
  localparam logic [3:0] ST_SORT_LD   = 4'd2;
  localparam logic [3:0] ST_SORT_CHK  = 4'd3;
  localparam logic [3:0] ST_SORT_CMP  = 4'd4;
  localparam logic [3:0] ST_SUM_RD    = 4'd5;
  localparam logic [3:0] ST_SUM_ACC   = 4'd6;
  localparam logic [3:0] ST_MERGE_RD  = 4'd7;
  localparam logic [3:0] ST_MERGE_ACC = 4'd8;
  localparam logic [3:0] ST_EMIT      = 4'd9;

  logic [3:0] state, state_next;
  logic [1:0] phase, phase_next;

  assign item_ready = (state == ST_LOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      phase <= SUM_A;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.sel_b  = (phase == SUM_B);
    cmd.code   = phase;
    cmd.last   = (phase == SUM_M);
    state_next = state;
    phase_next = phase;
    unique case (state)
      ST_LOAD: begin
        cmd.load = item_valid;
        if (item_valid && last_item) begin
          cmd.init_sort = 1'b1;
          phase_next    = SUM_A;
          state_next    = ST_SORT_KEY;
        end
      end
      ST_SORT_KEY: begin
        if (status.i_done) begin
          cmd.init_sum = 1'b1;
          state_next   = ST_SUM_RD;
        end else begin
          cmd.rd_i   = 1'b1;
          state_next = ST_SORT_LD;
        end
      end
      ST_SORT_LD: begin
        cmd.ld_key = 1'b1;
        state_next = ST_SORT_CHK;
      end
      ST_SORT_CHK: begin
        if (status.j_zero) begin
          cmd.wr_key = 1'b1;
          state_next = ST_SORT_KEY;
        end else begin
          cmd.rd_jm1 = 1'b1;
          state_next = ST_SORT_CMP;
        end
      end
      ST_SORT_CMP: begin
        if (status.key_lt) begin
          cmd.wr_shift = 1'b1;
          state_next   = ST_SORT_CHK;
        end else begin
          cmd.wr_key = 1'b1;
          state_next = ST_SORT_KEY;
        end
      end
      ST_SUM_RD: begin
        if (status.k_done) begin
          state_next = ST_EMIT;
        end else begin
          cmd.rd_k   = 1'b1;
          state_next = ST_SUM_ACC;
        end
      end
      ST_SUM_ACC: begin
        cmd.acc_k  = 1'b1;
        state_next = ST_SUM_RD;
      end
      ST_MERGE_RD: begin
        if (status.merge_done) begin
          state_next = ST_EMIT;
        end else begin
          cmd.rd_merge = 1'b1;
          state_next   = ST_MERGE_ACC;
        end
      end
      ST_MERGE_ACC: begin
        cmd.acc_merge = 1'b1;
        state_next    = ST_MERGE_RD;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          priority if (phase == SUM_A) begin
            cmd.init_sort = 1'b1;
            phase_next    = SUM_B;
            state_next    = ST_SORT_KEY;
          end else if (phase == SUM_B) begin
            cmd.init_merge = 1'b1;
            phase_next     = SUM_M;
            state_next     = ST_MERGE_RD;
          end else begin
            cmd.clr_counts = 1'b1;
            phase_next     = SUM_A;
            state_next     = ST_LOAD;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule

### hdl/smx_dpath.sv
module smx_dpath
  import smx_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  cmd_t                     cmd,
  output status_t                  status,
  input  logic                     which_list,
  input  logic signed [DATA_W-1:0] value,
  output logic                     result_valid,
  input  logic                     result_ready,
  output logic [1:0]               which_sum,
  output logic signed [DATA_W-1:0] index_xor_sum,
  output logic                     last_result
);

  logic [DATA_W-1:0] store_a [MAX_LEN];
  logic [DATA_W-1:0] store_b [MAX_LEN];
  logic [DATA_W-1:0] rdata_a, rdata_b, rd_sel;

  logic [LEN_W-1:0]  count_a, count_b, n_sel;
  logic [LEN_W-1:0]  i, ia, ib;
  logic [ADDR_W-1:0] j;
  logic [MRG_W-1:0]  k;
  logic [DATA_W-1:0] key, acc;

  logic [ADDR_W-1:0] ra, ra_a, ra_b, wa;
  logic [DATA_W-1:0] wd, take_v;
  logic              we_a, we_b, full_a, full_b, take_a;

  assign full_a = (count_a >= LEN_W'(MAX_LEN));
  assign full_b = (count_b >= LEN_W'(MAX_LEN));
  assign rd_sel = cmd.sel_b ? rdata_b : rdata_a;
  assign n_sel  = cmd.sel_b ? count_b : count_a;

  // merge pick: list a wins ties
  assign take_a = (ib >= count_b) ||
                  ((ia < count_a) && !($signed(rdata_b) < $signed(rdata_a)));
  assign take_v = take_a ? rdata_a : rdata_b;

  always_comb begin
    ra = '0;
    priority if (cmd.rd_i) begin
      ra = i[ADDR_W-1:0];
    end else if (cmd.rd_jm1) begin
      ra = j - ADDR_W'(1);
    end else if (cmd.rd_k) begin
      ra = k[ADDR_W-1:0];
    end
    ra_a = cmd.rd_merge ? ia[ADDR_W-1:0] : ra;
    ra_b = cmd.rd_merge ? ib[ADDR_W-1:0] : ra;
  end

  always_comb begin
    we_a = 1'b0;
    we_b = 1'b0;
    wa   = j;
    wd   = key;
    if (cmd.load) begin
      wd = value;
      if (which_list) begin
        we_b = !full_b;
        wa   = count_b[ADDR_W-1:0];
      end else begin
        we_a = !full_a;
        wa   = count_a[ADDR_W-1:0];
      end
    end else if (cmd.wr_key || cmd.wr_shift) begin
      we_a = !cmd.sel_b;
      we_b = cmd.sel_b;
      wd   = cmd.wr_shift ? rd_sel : key;
    end
  end

  always_ff @(posedge clk) begin
    if (we_a) begin
      store_a[wa] <= wd;
    end
    rdata_a <= store_a[ra_a];
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      store_b[wa] <= wd;
    end
    rdata_b <= store_b[ra_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_a <= '0;
      count_b <= '0;
    end else if (cmd.clr_counts) begin
      count_a <= '0;
      count_b <= '0;
    end else begin
      if (we_a && cmd.load) begin
        count_a <= count_a + LEN_W'(1);
      end
      if (we_b && cmd.load) begin
        count_b <= count_b + LEN_W'(1);
      end
    end
  end

  // insertion sort indexes and key
  always_ff @(posedge clk) begin
    if (cmd.init_sort) begin
      i <= LEN_W'(1);
    end else if (cmd.wr_key) begin
      i <= i + LEN_W'(1);
    end
    if (cmd.ld_key) begin
      j   <= i[ADDR_W-1:0];
      key <= rd_sel;
    end else if (cmd.wr_shift) begin
      j <= j - ADDR_W'(1);
    end
  end

  // sums and merge walk
  always_ff @(posedge clk) begin
    if (cmd.init_sum || cmd.init_merge) begin
      k   <= '0;
      acc <= '0;
      ia  <= '0;
      ib  <= '0;
    end else if (cmd.acc_k) begin
      acc <= acc + (DATA_W'(k) ^ rd_sel);
      k   <= k + MRG_W'(1);
    end else if (cmd.acc_merge) begin
      acc <= acc + (DATA_W'(k) ^ take_v);
      k   <= k + MRG_W'(1);
      if (take_a) begin
        ia <= ia + LEN_W'(1);
      end else begin
        ib <= ib + LEN_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      which_sum     <= cmd.code;
      index_xor_sum <= acc;
      last_result   <= cmd.last;
    end
  end

  always_comb begin
    status.i_done     = (i >= n_sel);
    status.j_zero     = (j == '0);
    status.key_lt     = ($signed(key) < $signed(rd_sel));
    status.k_done     = (k >= MRG_W'(n_sel));
    status.merge_done = (ia >= count_a) && (ib >= count_b);
    status.out_free   = !result_valid || result_ready;
  end

endmodule

### hdl/sort_merge_index_xor_sum.sv
// channel   direction  handshake                    payload
// item      in         item_valid / item_ready      which_list, value, last_item
// result    out        result_valid / result_ready  which_sum, index_xor_sum, last_result
//
// loading takes one request per cycle; the request flagged last_item starts the run
// each list is insertion sorted in its own ram: each element is read and taken as the key,
//   larger entries below it are shifted up one place, and the key is written where it stops
// the per-list sums and the merge read each element, then add its index xor value to the sum
// synchronous reset clears the counts and the result valid flag; the stores need no clearing
// a stalled result holds the sequencer only at the next result; loading resumes after the third

`include "sort_merge_index_xor_sum_assert.svh"

module sort_merge_index_xor_sum
  import smx_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  output logic                     item_ready,
  input  logic                     which_list,
  input  logic signed [DATA_W-1:0] value,
  input  logic                     last_item,
  output logic                     result_valid,
  input  logic                     result_ready,
  output logic [1:0]               which_sum,
  output logic signed [DATA_W-1:0] index_xor_sum,
  output logic                     last_result
);

  cmd_t    cmd;
  status_t status;

  // sequencer: load, sort a, sum a, sort b, sum b, merge
  smx_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .last_item  (last_item),
    .item_ready (item_ready),
    .status     (status),
    .cmd        (cmd)
  );

  // two list rams, sort and merge pointers, accumulator and result register
  smx_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .which_list    (which_list),
    .value         (value),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .which_sum     (which_sum),
    .index_xor_sum (index_xor_sum),
    .last_result   (last_result)
  );

  // a new result never lands on one that is still waiting
  `SMX_ASSERT_IMPLIES(a_emit_free, clk, rst, cmd.emit, status.out_free, "result overwritten")

  // the final result of a run carries the merged code and the last flag
  `SMX_ASSERT_NEXT(a_last_code, clk, rst, cmd.emit && cmd.last, result_valid && last_result && (which_sum == SUM_M), "bad final result")

  // after the final result the block is loading again
  `SMX_ASSERT_NEXT(a_reload, clk, rst, cmd.emit && cmd.last, item_ready, "not reloading after run")

endmodule
